FILE: hdl/slc_pkg.sv
// shared constants, codes and types for the set-associative lru cache model
package slc_pkg;

	localparam int MAX_SET_BITS   = 6;
	localparam int MAX_WAYS       = 8;
	localparam int STAMP_WIDTH    = 32;
	localparam int MAX_BLOCK_BITS = 6;
	localparam int MAX_SIZE       = 16;

	localparam int NSETS     = 1 << MAX_SET_BITS;
	localparam int DEPTH     = MAX_WAYS * NSETS;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
	localparam int IDX_W     = WAY_W + MAX_SET_BITS;
	localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
	localparam int BB_W      = 3;
	localparam int SH_W      = ((SB_W > BB_W) ? SB_W : BB_W) + 1;
	localparam int ADDR_W    = 64;
	localparam int TAG_W     = ADDR_W - 2;
	localparam int SIZE_W    = 5;
	localparam int CMD_W     = 2;
	localparam int CNT_W     = 32;
	localparam int BLK_CNT_W = 4;
	localparam int OC_W      = 2;

	localparam int IN_W   = 72;
	localparam int OUT_W  = 104;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;

	localparam logic [OC_W-1:0] OC_HIT   = 2'd0;
	localparam logic [OC_W-1:0] OC_COLD  = 2'd1;
	localparam logic [OC_W-1:0] OC_EVICT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	typedef struct packed {
		logic                   en;
		logic [IDX_W-1:0]       idx;
		logic                   tag_valid;
		logic [TAG_W-1:0]       tag;
		logic [STAMP_WIDTH-1:0] stamp;
	} slc_wr_t;

	typedef struct packed {
		logic                   valid;
		logic [TAG_W-1:0]       tag;
		logic [STAMP_WIDTH-1:0] stamp;
	} slc_rd_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] hit_way;
		logic             cold;
		logic [WAY_W-1:0] cold_way;
		logic             old;
		logic [WAY_W-1:0] old_way;
	} slc_scan_t;

endpackage

FILE: hdl/slc_store.sv
// line store: valid and tag memory plus stamp memory, one read port and one write port
module slc_store (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [slc_pkg::IDX_W-1:0] rd_idx,
	input  slc_pkg::slc_wr_t wr,
	output slc_pkg::slc_rd_t rd
);
	import slc_pkg::*;

	logic [TAG_W:0]         tag_mem [DEPTH];
	logic [STAMP_WIDTH-1:0] stamp_mem [DEPTH];
	logic [TAG_W:0]         tag_word_q;
	logic [STAMP_WIDTH-1:0] stamp_word_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			tag_mem[wr.idx]   <= {wr.tag_valid, wr.tag};
			stamp_mem[wr.idx] <= wr.stamp;
		end
		if (rd_en) begin
			tag_word_q   <= tag_mem[rd_idx];
			stamp_word_q <= stamp_mem[rd_idx];
		end
	end

	assign rd.valid = tag_word_q[TAG_W];
	assign rd.tag   = tag_word_q[TAG_W-1:0];
	assign rd.stamp = stamp_word_q;

endmodule

FILE: hdl/slc_way_scan.sv
// shared tag and stamp comparator, walks the ways of one set one per cycle
module slc_way_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            cmp_en,
	input  logic [slc_pkg::WAY_W-1:0] cmp_way,
	input  slc_pkg::slc_rd_t rd,
	input  logic [slc_pkg::TAG_W-1:0] tag,
	output slc_pkg::slc_scan_t res
);
	import slc_pkg::*;

	slc_scan_t              res_q;
	logic [STAMP_WIDTH-1:0] old_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= '0;
			old_stamp_q <= '0;
		end else if (start) begin
			res_q <= '0;
		end else if (cmp_en) begin
			if (rd.valid) begin
				if (rd.tag == tag) begin
					if (!res_q.hit) begin
						res_q.hit     <= 1'b1;
						res_q.hit_way <= cmp_way;
					end
				end else if (!res_q.old || rd.stamp < old_stamp_q) begin
					// strict compare keeps the lowest way on a tie
					res_q.old     <= 1'b1;
					res_q.old_way <= cmp_way;
					old_stamp_q   <= rd.stamp;
				end
			end else if (!res_q.cold) begin
				res_q.cold     <= 1'b1;
				res_q.cold_way <= cmp_way;
			end
		end
	end

	assign res = res_q;

endmodule

FILE: hdl/set_assoc_lru_cache_sim.sv
// Set-associative cache model with LRU replacement and hit, miss and
// eviction counting. After reset the block sweeps its 512-entry line store
// to clear the valid bits and accepts no access during that sweep
// (configuration writes are taken at any time). An access with command
// other, or with size zero, is consumed without a lookup. Any other access
// passes through ST_SETUP, ST_SEARCH, ST_DRAIN, ST_WRITE and ST_RESULT for
// each block it touches, at most 8 blocks: the line store has one read
// port, so the ways of a set are read and compared one per cycle through a
// single tag and stamp comparator, then the chosen line is written and
// the block's result enters the output register when it is free. The next
// access is accepted once the last result of the current one is in it.
module set_assoc_lru_cache_sim (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cmd[1:0], address[65:2], access_size[70:66], zero fill
	input  logic [slc_pkg::IN_W-1:0]          s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// outcome[1:0], extra_hit[2], hit_count[34:3], miss_count[66:35],
	// evict_count[98:67], zero fill
	output logic [slc_pkg::OUT_W-1:0]         m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import slc_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SETUP  = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_WRITE  = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	logic [2:0]             state_q;
	logic [BB_W-1:0]        set_bits_q;
	logic [WAY_CNT_W-1:0]   ways_cfg_q;
	logic [BB_W-1:0]        block_bits_q;

	logic [SB_W-1:0]        sb_eff;
	logic [BB_W-1:0]        bb_eff;
	logic [WAY_CNT_W-1:0]   ways_eff;

	logic [IDX_W-1:0]       clr_cnt_q;
	logic [STAMP_WIDTH-1:0] access_time_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	logic                   modify_q;
	logic [ADDR_W-1:0]      blk_addr_q;
	logic [BLK_CNT_W-1:0]   blocks_left_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0]       tag_q;
	logic [WAY_CNT_W-1:0]   issue_cnt_q;
	logic                   rd_pend_s1;
	logic [WAY_W-1:0]       rd_way_s1;
	logic [OC_W-1:0]        outcome_q;
	logic [CNT_W-1:0]       hit_q, miss_q, evict_q;

	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;
	logic                   out_last_q;

	logic [CMD_W-1:0]       in_cmd;
	logic [ADDR_W-1:0]      in_addr;
	logic [SIZE_W-1:0]      in_size;
	logic [SIZE_W-1:0]      size_clamped;
	logic                   in_active;
	logic                   in_xfer;
	logic [6:0]             bsize7;
	logic [6:0]             blk_cnt7;
	logic [ADDR_W-1:0]      base_addr;
	logic [ADDR_W-1:0]      bsize64;
	logic [ADDR_W-1:0]      addr_shifted;
	logic [SH_W-1:0]        tag_sh;
	logic [ADDR_W-1:0]      tag_full;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic                   out_free;
	logic                   last_issue;
	logic [WAY_W-1:0]       victim_way;
	logic [OC_W-1:0]        victim_oc;
	logic [CNT_W-1:0]       hit_step, hit_n, miss_n, evict_n;

	slc_wr_t   wr;
	slc_rd_t   rd;
	slc_scan_t scan;

	// effective geometry
	always_comb begin
		if (set_bits_q == '0)
			sb_eff = SB_W'(1);
		else if (int'(set_bits_q) > MAX_SET_BITS)
			sb_eff = SB_W'(MAX_SET_BITS);
		else
			sb_eff = SB_W'(set_bits_q);

		if (block_bits_q == '0)
			bb_eff = BB_W'(1);
		else if (int'(block_bits_q) > MAX_BLOCK_BITS)
			bb_eff = BB_W'(MAX_BLOCK_BITS);
		else
			bb_eff = block_bits_q;

		if (ways_cfg_q == '0)
			ways_eff = WAY_CNT_W'(1);
		else if (int'(ways_cfg_q) > MAX_WAYS)
			ways_eff = WAY_CNT_W'(MAX_WAYS);
		else
			ways_eff = ways_cfg_q;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= BB_W'(4);
			ways_cfg_q   <= WAY_CNT_W'(1);
			block_bits_q <= BB_W'(4);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[BB_W-1:0];
				CFG_WAYS:       ways_cfg_q   <= WAY_CNT_W'(cfg_data);
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BB_W-1:0];
				default:        ;
			endcase
		end
	end

	// input decode
	assign in_cmd       = s_tdata[1:0];
	assign in_addr      = s_tdata[65:2];
	assign in_size      = s_tdata[70:66];
	assign size_clamped = (int'(in_size) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : in_size;
	assign in_active    = (in_cmd == CMD_LOAD || in_cmd == CMD_MODIFY) && in_size != '0;
	assign s_tready     = (state_q == ST_IDLE);
	assign in_xfer      = s_tvalid && s_tready;

	assign bsize7    = 7'd1 << bb_eff;
	assign blk_cnt7  = (7'(size_clamped) + bsize7 - 7'd1) >> bb_eff;
	assign bsize64   = 64'd1 << bb_eff;
	assign base_addr = in_addr & ({ADDR_W{1'b1}} << bb_eff);

	// set and tag of the current block
	assign addr_shifted = blk_addr_q >> bb_eff;
	assign set_mask     = ~({MAX_SET_BITS{1'b1}} << sb_eff);
	assign tag_sh       = SH_W'(sb_eff) + SH_W'(bb_eff);
	assign tag_full     = blk_addr_q >> tag_sh;

	assign last_issue = (issue_cnt_q == ways_eff - 1'b1);
	assign out_free   = !out_valid_q || m_tready;

	always_comb begin
		if (scan.hit) begin
			victim_way = scan.hit_way;
			victim_oc  = OC_HIT;
		end else if (scan.cold) begin
			victim_way = scan.cold_way;
			victim_oc  = OC_COLD;
		end else begin
			victim_way = scan.old_way;
			victim_oc  = OC_EVICT;
		end
	end

	// memory write: clearing sweep or line update
	always_comb begin
		wr = '0;
		if (state_q == ST_CLEAR) begin
			wr.en  = 1'b1;
			wr.idx = clr_cnt_q;
		end else if (state_q == ST_WRITE) begin
			wr.en        = 1'b1;
			wr.idx       = {victim_way, set_q};
			wr.tag_valid = 1'b1;
			wr.tag       = tag_q;
			wr.stamp     = stamp_q;
		end
	end

	// counters after this block
	always_comb begin
		hit_step = (outcome_q == OC_HIT) ? sat_inc(hit_q) : hit_q;
		hit_n    = modify_q ? sat_inc(hit_step) : hit_step;
		miss_n   = (outcome_q == OC_HIT) ? miss_q : sat_inc(miss_q);
		evict_n  = (outcome_q == OC_EVICT) ? sat_inc(evict_q) : evict_q;
	end

	slc_store u_store (
		.clk    (clk),
		.rd_en  (state_q == ST_SEARCH),
		.rd_idx ({issue_cnt_q[WAY_W-1:0], set_q}),
		.wr     (wr),
		.rd     (rd)
	);

	slc_way_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_SETUP),
		.cmp_en  (rd_pend_s1),
		.cmp_way (rd_way_s1),
		.rd      (rd),
		.tag     (tag_q),
		.res     (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			access_time_q <= '0;
			hit_q         <= '0;
			miss_q        <= '0;
			evict_q       <= '0;
			blocks_left_q <= '0;
			issue_cnt_q   <= '0;
			rd_pend_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_SEARCH);
			if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IDX_W'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer) begin
						if (access_time_q != '1)
							access_time_q <= access_time_q + 1'b1;
						blocks_left_q <= BLK_CNT_W'(blk_cnt7);
						if (in_active)
							state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					issue_cnt_q <= '0;
					state_q     <= ST_SEARCH;
				end
				ST_SEARCH: begin
					issue_cnt_q <= issue_cnt_q + 1'b1;
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						hit_q         <= hit_n;
						miss_q        <= miss_n;
						evict_q       <= evict_n;
						blocks_left_q <= blocks_left_q - 1'b1;
						if (blocks_left_q == BLK_CNT_W'(1))
							state_q <= ST_IDLE;
						else
							state_q <= ST_SETUP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_way_s1 <= issue_cnt_q[WAY_W-1:0];
		if (in_xfer) begin
			stamp_q    <= access_time_q;
			modify_q   <= (in_cmd == CMD_MODIFY);
			blk_addr_q <= base_addr;
		end
		if (state_q == ST_SETUP) begin
			set_q <= addr_shifted[MAX_SET_BITS-1:0] & set_mask;
			tag_q <= tag_full[TAG_W-1:0];
		end
		if (state_q == ST_WRITE)
			outcome_q <= victim_oc;
		if (state_q == ST_RESULT && out_free) begin
			out_data_q <= {5'b0, evict_n, miss_n, hit_n, modify_q, outcome_q};
			out_last_q <= (blocks_left_q == BLK_CNT_W'(1));
			blk_addr_q <= blk_addr_q + bsize64;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// a set always yields a line to write: a hit, an empty way or an oldest line
	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> scan.hit || scan.cold || scan.old)
		else $error("no line chosen for write");

	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evict_q <= miss_q)
		else $error("evictions exceed misses");

	a_hit_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hit_q >= $past(hit_q))
		else $error("hit total went down");

	a_blocks_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |-> blocks_left_q != '0 && blocks_left_q <= BLK_CNT_W'(8))
		else $error("block count out of range");

endmodule
